// File: hw/rtl/fwia_pkg.sv
// ----------------------------------------------------------------------------
// fwia_pkg
// Opcodes, kinds, datapath commands and status types for the integer ALU.
// ----------------------------------------------------------------------------
package fwia_pkg;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_MOD = 5'd4;
  localparam logic [4:0] OP_POW = 5'd5;
  localparam logic [4:0] OP_NEG = 5'd6;
  localparam logic [4:0] OP_ABS = 5'd7;
  localparam logic [4:0] OP_AND = 5'd8;
  localparam logic [4:0] OP_OR  = 5'd9;
  localparam logic [4:0] OP_XOR = 5'd10;
  localparam logic [4:0] OP_INV = 5'd11;
  localparam logic [4:0] OP_SHL = 5'd12;
  localparam logic [4:0] OP_SHR = 5'd13;
  localparam logic [4:0] OP_EQ  = 5'd14;
  localparam logic [4:0] OP_NE  = 5'd15;
  localparam logic [4:0] OP_LT  = 5'd16;
  localparam logic [4:0] OP_LE  = 5'd17;
  localparam logic [4:0] OP_GT  = 5'd18;
  localparam logic [4:0] OP_GE  = 5'd19;
  localparam logic [4:0] OP_BOOL = 5'd20;

  localparam logic [1:0] KIND_S32 = 2'd0;
  localparam logic [1:0] KIND_U32 = 2'd1;
  localparam logic [1:0] KIND_S64 = 2'd2;
  localparam logic [1:0] KIND_U64 = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_NEGEXP  = 2'd2;
  localparam logic [1:0] ST_NEGSHFT = 2'd3;

  localparam logic [63:0] LOW32_MASK = 64'h0000_0000_FFFF_FFFF;

  localparam logic [1:0] CLS_SIMPLE = 2'd0;
  localparam logic [1:0] CLS_MUL    = 2'd1;
  localparam logic [1:0] CLS_DIV    = 2'd2;
  localparam logic [1:0] CLS_POW    = 2'd3;

  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LOAD      = 4'd1;
  localparam logic [3:0] CMD_MUL_AB    = 4'd2;
  localparam logic [3:0] CMD_MUL_RB    = 4'd3;
  localparam logic [3:0] CMD_MUL_BB    = 4'd4;
  localparam logic [3:0] CMD_MUL_STEP  = 4'd5;
  localparam logic [3:0] CMD_RES_TAKE  = 4'd6;
  localparam logic [3:0] CMD_BASE_TAKE = 4'd7;
  localparam logic [3:0] CMD_DIV_STEP  = 4'd8;
  localparam logic [3:0] CMD_FINISH    = 4'd9;

  typedef struct packed {
    logic [3:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cls;
    logic       mul_done;
    logic       div_last;
    logic       exp_zero;
    logic       exp_lsb;
  } dp_stat_t;

endpackage

// File: hw/rtl/fwia_ctrl.sv
// ----------------------------------------------------------------------------
// fwia_ctrl
// Sequencer: dispatches each operation and steps the shared multiplier,
// divider and power loop.
// ----------------------------------------------------------------------------
module fwia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output fwia_pkg::dp_cmd_t cmd,
  input  fwia_pkg::dp_stat_t stat
);
  import fwia_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_PTEST = 4'd5;
  localparam logic [3:0] S_PM1   = 4'd6;
  localparam logic [3:0] S_PSQ   = 4'd7;
  localparam logic [3:0] S_PM2   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.code  = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.code  = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cls)
          CLS_MUL: begin
            cmd.code  = CMD_MUL_AB;
            state_nxt = S_MUL;
          end
          CLS_DIV: state_nxt = S_DIV;
          CLS_POW: state_nxt = S_PTEST;
          default: begin
            cmd.code  = CMD_FINISH;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        if (stat.mul_done) begin
          cmd.code  = CMD_FINISH;
          state_nxt = S_IDLE;
        end else begin
          cmd.code = CMD_MUL_STEP;
        end
      end
      S_DIV: begin
        cmd.code = CMD_DIV_STEP;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.code  = CMD_FINISH;
        state_nxt = S_IDLE;
      end
      S_PTEST: begin
        if (stat.exp_zero) begin
          cmd.code  = CMD_FINISH;
          state_nxt = S_IDLE;
        end else if (stat.exp_lsb) begin
          cmd.code  = CMD_MUL_RB;
          state_nxt = S_PM1;
        end else begin
          cmd.code  = CMD_MUL_BB;
          state_nxt = S_PM2;
        end
      end
      S_PM1: begin
        if (stat.mul_done) begin
          cmd.code  = CMD_RES_TAKE;
          state_nxt = S_PSQ;
        end else begin
          cmd.code = CMD_MUL_STEP;
        end
      end
      S_PSQ: begin
        cmd.code  = CMD_MUL_BB;
        state_nxt = S_PM2;
      end
      S_PM2: begin
        if (stat.mul_done) begin
          cmd.code  = CMD_BASE_TAKE;
          state_nxt = S_PTEST;
        end else begin
          cmd.code = CMD_MUL_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    done_nxt = (cmd.code == CMD_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;

endmodule

// File: hw/rtl/fwia_dp.sv
// ----------------------------------------------------------------------------
// fwia_dp
// Datapath: operand registers, shift-add multiplier, restoring divider,
// power accumulator and the result formatter.
// ----------------------------------------------------------------------------
module fwia_dp (
  input  logic               clk,
  input  fwia_pkg::dp_cmd_t  cmd,
  output fwia_pkg::dp_stat_t stat,
  input  logic [4:0]         in_func,
  input  logic [1:0]         in_kind,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  output logic signed [63:0] out_result_value,
  output logic               out_compare_flag,
  output logic [1:0]         out_status
);
  import fwia_pkg::*;

  logic [4:0]  func_r;
  logic [1:0]  kind_r;
  logic [63:0] a_r, b_r;
  logic [63:0] mc_r, mp_r, pr_r;
  logic [63:0] base_r, exp_r, res_r;
  logic [63:0] rem_r, quo_r, dvs_r;
  logic [5:0]  cnt_r;
  logic [63:0] val_r;
  logic        flag_r;
  logic [1:0]  st_r;

  logic        in_sgn, sgn, big_shift, lt_ab, lt_ba;
  logic [64:0] trial;
  logic [63:0] val, mag_q, mag_r;
  logic        flag;
  logic [1:0]  st;
  logic [1:0]  cls;

  assign in_sgn = !in_kind[0];
  assign sgn    = !kind_r[0];
  assign trial  = {rem_r, quo_r[63]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_LOAD: begin
        func_r <= in_func;
        kind_r <= in_kind;
        a_r    <= in_operand_a;
        b_r    <= in_operand_b;
        base_r <= in_operand_a;
        exp_r  <= in_operand_b;
        res_r  <= 64'd1;
        rem_r  <= 64'd0;
        cnt_r  <= 6'd0;
        quo_r  <= (in_sgn && in_operand_a[63]) ? 64'd0 - in_operand_a : in_operand_a;
        dvs_r  <= (in_sgn && in_operand_b[63]) ? 64'd0 - in_operand_b : in_operand_b;
      end
      CMD_MUL_AB: begin
        mc_r <= a_r;
        mp_r <= b_r;
        pr_r <= 64'd0;
      end
      CMD_MUL_RB: begin
        mc_r <= res_r;
        mp_r <= base_r;
        pr_r <= 64'd0;
      end
      CMD_MUL_BB: begin
        mc_r <= base_r;
        mp_r <= base_r;
        pr_r <= 64'd0;
      end
      CMD_MUL_STEP: begin
        if (mp_r[0]) pr_r <= pr_r + mc_r;
        mc_r <= {mc_r[62:0], 1'b0};
        mp_r <= {1'b0, mp_r[63:1]};
      end
      CMD_RES_TAKE: res_r <= pr_r;
      CMD_BASE_TAKE: begin
        base_r <= pr_r;
        exp_r  <= {1'b0, exp_r[63:1]};
      end
      CMD_DIV_STEP: begin
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], quo_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
      end
      CMD_FINISH: begin
        val_r  <= val;
        flag_r <= flag;
        st_r   <= st;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (func_r)
      OP_MUL: cls = CLS_MUL;
      OP_DIV, OP_MOD: cls = (b_r == 64'd0) ? CLS_SIMPLE : CLS_DIV;
      OP_POW: cls = b_r[63] ? CLS_SIMPLE : CLS_POW;
      default: cls = CLS_SIMPLE;
    endcase
  end
  assign stat.cls      = cls;
  assign stat.mul_done = (mp_r == 64'd0);
  assign stat.div_last = (cnt_r == 6'd63);
  assign stat.exp_zero = (exp_r == 64'd0);
  assign stat.exp_lsb  = exp_r[0];

  // signed or unsigned compare; sign bits are flipped for signed kinds only
  assign lt_ab = ({a_r[63] ^ sgn, a_r[62:0]} < {b_r[63] ^ sgn, b_r[62:0]});
  assign lt_ba = ({b_r[63] ^ sgn, b_r[62:0]} < {a_r[63] ^ sgn, a_r[62:0]});
  assign big_shift = (|b_r[62:6]) || (!kind_r[1] && b_r[5]);
  assign mag_q = (sgn && (a_r[63] ^ b_r[63])) ? 64'd0 - quo_r : quo_r;
  assign mag_r = (sgn && a_r[63]) ? 64'd0 - rem_r : rem_r;

  always_comb begin
    val  = 64'd0;
    flag = 1'b0;
    st   = ST_OK;
    case (func_r)
      OP_ADD: val = a_r + b_r;
      OP_SUB: val = a_r - b_r;
      OP_MUL: val = pr_r;
      OP_DIV: begin
        if (b_r == 64'd0) st = ST_DIVZERO;
        else val = mag_q;
      end
      OP_MOD: begin
        if (b_r == 64'd0) st = ST_DIVZERO;
        else val = mag_r;
      end
      OP_POW: begin
        if (b_r[63]) st = ST_NEGEXP;
        else val = res_r;
      end
      OP_NEG: val = 64'd0 - a_r;
      OP_ABS: val = (sgn && a_r[63]) ? 64'd0 - a_r : a_r;
      OP_AND: val = a_r & b_r;
      OP_OR:  val = a_r | b_r;
      OP_XOR: val = a_r ^ b_r;
      OP_INV: val = ~a_r;
      OP_SHL: begin
        if (b_r[63]) st = ST_NEGSHFT;
        else if (!big_shift) val = a_r << b_r[5:0];
      end
      OP_SHR: begin
        if (b_r[63]) st = ST_NEGSHFT;
        else if (big_shift) val = (sgn && a_r[63]) ? ~64'd0 : 64'd0;
        else if (sgn) val = 64'($signed(a_r) >>> b_r[5:0]);
        else val = a_r >> b_r[5:0];
      end
      OP_EQ:   flag = (a_r == b_r);
      OP_NE:   flag = (a_r != b_r);
      OP_LT:   flag = lt_ab;
      OP_LE:   flag = !lt_ba;
      OP_GT:   flag = lt_ba;
      OP_GE:   flag = !lt_ab;
      OP_BOOL: flag = (a_r != 64'd0);
      default: ;
    endcase
    if (st != ST_OK) begin
      val = 64'd0;
    end else if (func_r <= OP_SHR) begin
      case (kind_r)
        KIND_S32: val = val[31] ? (val | ~LOW32_MASK) : (val & LOW32_MASK);
        KIND_U32: val = val & LOW32_MASK;
        default: ;
      endcase
    end
  end

  assign out_result_value = val_r;
  assign out_compare_flag = flag_r;
  assign out_status       = st_r;

endmodule

// File: hw/rtl/fixed_width_integer_alu.sv
// ----------------------------------------------------------------------------
// fixed_width_integer_alu
// Integer ALU for signed/unsigned 32- and 64-bit kinds.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_func, in_kind, in_operand_a and in_operand_b and raise start;
//   the transfer happens at a rising edge with start high and busy low.
//   busy stays high until the result is formatted. The result appears on
//   out_result_value, out_compare_flag and out_status for exactly one cycle
//   with out_strobe high; the receiver cannot stall, so it must take it then.
// Sequencing per operation class:
//   simple ops and errors: formatted straight from dispatch.
//   mul: the shift-add multiplier retires one multiplier bit per cycle
//     and stops once no set bit of operand_b is left.
//   div/mod: one quotient bit per cycle in the restoring divider.
//   pow: per exponent bit one squaring plus one multiply when the bit is
//     set, each on the same multiplier.
// One item at a time; the next start is taken once busy drops.
// Reset (synchronous, rst_n low) returns the sequencer to idle and clears
// the strobe; no result is pending afterward.
// ----------------------------------------------------------------------------
module fixed_width_integer_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         in_func,
  input  logic [1:0]         in_kind,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  output logic               out_strobe,
  output logic signed [63:0] out_result_value,
  output logic               out_compare_flag,
  output logic [1:0]         out_status
);
  import fwia_pkg::*;

  dp_cmd_t  cmd;   // sequencer -> datapath
  dp_stat_t stat;  // datapath -> sequencer

  fwia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_strobe),
    .cmd   (cmd),
    .stat  (stat)
  );

  fwia_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_kind          (in_kind),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_result_value (out_result_value),
    .out_compare_flag (out_compare_flag),
    .out_status       (out_status)
  );

endmodule

// File: bench/tb_fixed_width_integer_alu.sv
// ----------------------------------------------------------------------------
// tb_fixed_width_integer_alu
// Self-checking bench: directed corner operations, then random commands with
// random start gaps; every strobed result is compared against a local model.
// ----------------------------------------------------------------------------
module tb_fixed_width_integer_alu;
  import fwia_pkg::*;

  localparam int          IDLE_LIMIT = 40000;  // pow runs longest
  localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [4:0]  func;
    logic [1:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic [63:0] value;
    logic        flag;
    logic [1:0]  status;
  } alu_res_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [4:0]         in_func;
  logic [1:0]         in_kind;
  logic signed [63:0] in_operand_a;
  logic signed [63:0] in_operand_b;
  logic               out_strobe;
  logic signed [63:0] out_result_value;
  logic               out_compare_flag;
  logic [1:0]         out_status;

  alu_cmd_t cmd_q[$];    // commands waiting for the driver
  alu_res_t result_q[$]; // predicted results, oldest first
  int       errors;
  int       idle_cycles;
  bit       gaps_on;
  bit       stim_done;

  fixed_width_integer_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_kind(in_kind),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_strobe(out_strobe), .out_result_value(out_result_value),
    .out_compare_flag(out_compare_flag), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---- prediction ----------------------------------------------------------

  function automatic logic [63:0] fit_kind(logic [63:0] v, logic [1:0] kind);
    if (kind == KIND_S32) return {{32{v[31]}}, v[31:0]};
    if (kind == KIND_U32) return {32'd0, v[31:0]};
    return v;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Signed less-than by flipping the sign bit, unsigned otherwise.
  function automatic bit lt(logic [63:0] x, logic [63:0] y, bit sgn);
    if (sgn) begin
      x ^= SIGN_BIT;
      y ^= SIGN_BIT;
    end
    return x < y;
  endfunction

  function automatic alu_res_t alu_predict(alu_cmd_t c);
    alu_res_t    r;
    logic [63:0] q;
    logic [63:0] base;
    logic [63:0] e;
    bit          sgn;
    int unsigned bits;
    sgn  = (c.kind == KIND_S32) || (c.kind == KIND_S64);
    bits = (c.kind == KIND_S32 || c.kind == KIND_U32) ? 32 : 64;
    r    = '0;
    case (c.func)
      OP_ADD: r.value = c.a + c.b;
      OP_SUB: r.value = c.a - c.b;
      OP_MUL: r.value = c.a * c.b;
      OP_DIV, OP_MOD: begin
        if (c.b == 0) r.status = ST_DIVZERO;
        else if (!sgn) r.value = (c.func == OP_DIV) ? c.a / c.b : c.a % c.b;
        else if (c.func == OP_DIV) begin
          q = mag(c.a) / mag(c.b);
          r.value = ((c.a ^ c.b) & SIGN_BIT) != 0 ? -q : q;
        end else begin
          q = mag(c.a) % mag(c.b);
          r.value = c.a[63] ? -q : q;
        end
      end
      OP_POW: begin
        if (c.b[63]) r.status = ST_NEGEXP;
        else begin
          // square-and-multiply, wrapping at 64 bits
          r.value = 64'd1;
          base    = c.a;
          e       = c.b;
          while (e != 0) begin
            if (e[0]) r.value = r.value * base;
            base = base * base;
            e    = e >> 1;
          end
        end
      end
      OP_NEG: r.value = -c.a;
      OP_ABS: r.value = (sgn && c.a[63]) ? -c.a : c.a;
      OP_AND: r.value = c.a & c.b;
      OP_OR:  r.value = c.a | c.b;
      OP_XOR: r.value = c.a ^ c.b;
      OP_INV: r.value = ~c.a;
      OP_SHL: begin
        if (c.b[63]) r.status = ST_NEGSHFT;
        else if (c.b >= bits) r.value = '0;
        else r.value = c.a << c.b[5:0];
      end
      OP_SHR: begin
        if (c.b[63]) r.status = ST_NEGSHFT;
        else if (c.b >= bits) r.value = (sgn && c.a[63]) ? '1 : '0;
        else if (sgn) r.value = $signed(c.a) >>> c.b[5:0];
        else r.value = c.a >> c.b[5:0];
      end
      OP_EQ:   r.flag = (c.a == c.b);
      OP_NE:   r.flag = (c.a != c.b);
      OP_LT:   r.flag = lt(c.a, c.b, sgn);
      OP_LE:   r.flag = !lt(c.b, c.a, sgn);
      OP_GT:   r.flag = lt(c.b, c.a, sgn);
      OP_GE:   r.flag = !lt(c.a, c.b, sgn);
      OP_BOOL: r.flag = (c.a != 0);
      default: ;  // unused opcodes: all zero, ok
    endcase
    if (r.status != ST_OK) r.value = '0;
    else if (c.func <= OP_SHR) r.value = fit_kind(r.value, c.kind);
    return r;
  endfunction

  // ---- stimulus ------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operands biased toward corners: extremes, 32-bit edges and small values.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '1;
      3: return 64'h0000_0000_8000_0000;
      4: return {32'd0, $urandom()};
      5: return {{32{1'b1}}, $urandom()};
      6: return 64'($urandom_range(0, 8));
      default: return rand64();
    endcase
  endfunction

  function automatic alu_cmd_t random_cmd();
    alu_cmd_t c;
    c.func = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
                                          : 5'($urandom_range(0, 20));
    c.kind = 2'($urandom_range(0, 3));
    c.a    = pick_operand();
    c.b    = pick_operand();
    case (c.func)
      // keep most multiplies and powers short; pow exponents small
      OP_MUL: if ($urandom_range(0, 3) != 0) c.b = 64'($urandom_range(0, 65535));
      OP_POW: begin
        if ($urandom_range(0, 9) == 0) c.b = rand64() | SIGN_BIT;
        else if ($urandom_range(0, 9) == 0) c.b = 64'($urandom_range(0, 65535));
        else c.b = 64'($urandom_range(0, 70));
      end
      OP_SHL, OP_SHR: begin
        if ($urandom_range(0, 7) == 0) c.b = rand64() | SIGN_BIT;
        else if ($urandom_range(0, 7) == 0) c.b = rand64() & ~SIGN_BIT;
        else c.b = 64'($urandom_range(0, 70));
      end
      OP_DIV, OP_MOD: if ($urandom_range(0, 9) == 0) c.b = '0;
      OP_EQ, OP_NE, OP_LE, OP_GE: if ($urandom_range(0, 3) == 0) c.b = c.a;
      OP_BOOL: if ($urandom_range(0, 3) == 0) c.a = '0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic push_cmd(logic [4:0] f, logic [1:0] k, logic [63:0] a,
                          logic [63:0] b);
    cmd_q.push_back('{func: f, kind: k, a: a, b: b});
  endtask

  initial begin
    errors    = 0;
    gaps_on   = 1'b1;
    stim_done = 1'b0;

    // directed corners
    push_cmd(OP_ADD, KIND_S64, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
    push_cmd(OP_SUB, KIND_U32, 64'd0, 64'd1);
    push_cmd(OP_MUL, KIND_S32, 64'hFFFF_FFFF_FFFF_FFFF, '1);
    push_cmd(OP_DIV, KIND_S64, 64'h8000_0000_0000_0000, '1);   // MIN / -1
    push_cmd(OP_MOD, KIND_S64, 64'h8000_0000_0000_0000, '1);   // MIN mod -1
    push_cmd(OP_DIV, KIND_U64, 64'h8000_0000_0000_0000, 64'd3);
    push_cmd(OP_MOD, KIND_S32, -64'sd7, 64'd2);
    push_cmd(OP_DIV, KIND_U32, 64'd5, 64'd0);               // divide by zero
    push_cmd(OP_MOD, KIND_S32, 64'd5, 64'd0);
    push_cmd(OP_POW, KIND_U64, 64'd3, 64'd40);
    push_cmd(OP_POW, KIND_S64, 64'd2, 64'd0);
    push_cmd(OP_POW, KIND_S32, 64'd2, SIGN_BIT);            // negative exponent
    push_cmd(OP_NEG, KIND_S32, 64'h0000_0000_8000_0000, '0);
    push_cmd(OP_ABS, KIND_U32, '1, '0);                     // unsigned abs
    push_cmd(OP_ABS, KIND_S64, 64'h8000_0000_0000_0000, '0);
    push_cmd(OP_AND, KIND_U64, '1, 64'h0123_4567_89AB_CDEF);
    push_cmd(OP_OR,  KIND_S32, 64'h8000_0000, 64'd1);
    push_cmd(OP_XOR, KIND_S64, '1, 64'h5555_5555_5555_5555);
    push_cmd(OP_INV, KIND_U32, '0, '1);
    push_cmd(OP_SHL, KIND_S32, 64'd1, 64'd32);              // shift >= width
    push_cmd(OP_SHR, KIND_S64, 64'h8000_0000_0000_0000, 64'd64);
    push_cmd(OP_SHR, KIND_U32, '1, 64'd31);
    push_cmd(OP_SHL, KIND_U64, 64'd1, '1);                  // negative shift
    push_cmd(OP_LT, KIND_S32, '1, 64'd0);
    push_cmd(OP_GE, KIND_U64, '1, 64'd0);
    push_cmd(OP_BOOL, KIND_U32, 64'h1_0000_0000, '0);
    push_cmd(5'd31, KIND_U64, '1, '1);                      // unused opcode
    for (int i = 0; i < 400; i++) cmd_q.push_back(random_cmd());
  end

  // ---- reset and driver ----------------------------------------------------

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  initial begin
    start        = 1'b0;
    in_func      = '0;
    in_kind      = '0;
    in_operand_a = '0;
    in_operand_b = '0;
  end

  // A start left high by the previous negedge and seen with busy low was
  // taken at the rising edge just passed; record the prediction then.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      result_q.push_back(alu_predict('{func: in_func, kind: in_kind,
                                       a: in_operand_a, b: in_operand_b}));
      void'(cmd_q.pop_front());
    end
  end

  // Random gaps except for a quiet stretch in the middle of the random part.
  always @(negedge clk) begin
    if (rst_n && !start || rst_n && !busy) begin
      gaps_on <= !(cmd_q.size() > 150 && cmd_q.size() < 250);
      if (cmd_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 33)) begin
        start        <= 1'b1;
        in_func      <= cmd_q[0].func;
        in_kind      <= cmd_q[0].kind;
        in_operand_a <= cmd_q[0].a;
        in_operand_b <= cmd_q[0].b;
      end else begin
        start <= 1'b0;
      end
      if (cmd_q.size() == 0) stim_done <= 1'b1;
    end
  end

  // ---- monitor and watchdog ------------------------------------------------

  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_strobe) begin
      if (result_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_result_value);
          errors++;
        end
        if (out_compare_flag !== want.flag) begin
          $error("compare_flag: expected %b, got %b", want.flag, out_compare_flag);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles > IDLE_LIMIT) begin
      $display("fixed_width_integer_alu: mismatch");
      $finish;
    end
  end

  initial begin
    wait (stim_done && result_q.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("fixed_width_integer_alu: match");
    end else begin
      $display("fixed_width_integer_alu: mismatch");
    end
    $finish;
  end

endmodule
